// ===== rtl/channel_matrix_mixer_core_assert.svh =====
// Assertion macros shared by the mixer RTL modules.
`ifndef CHANNEL_MATRIX_MIXER_CORE_ASSERT_SVH
`define CHANNEL_MATRIX_MIXER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CMM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mixer assertion failed");

// Next-cycle implication, checked outside reset.
`define CMM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mixer assertion failed");

`endif

// ===== rtl/cmm_pkg.sv =====
// Package: word types, codes and constants of the channel matrix mixer.
`default_nettype none

package cmm_pkg;

    localparam int CMM_MAX_CHANNELS   = 8;
    localparam int CMM_COEF_FRAC_BITS = 12;

    localparam int VALUE_W  = 16;
    localparam int PROD_W   = 32;
    localparam int ACC_W    = 40;
    localparam int INDEX_W  = 6;
    localparam int ACTION_W = 2;
    localparam int DEST_W   = 3;
    localparam int CFG_W    = 4;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // Action codes of an input word
    localparam logic [ACTION_W-1:0] ACT_LOAD   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_SAMPLE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_PRIME  = 2'd2;

    // Register indexes (paddr[2])
    localparam logic REG_SRC  = 1'b0;
    localparam logic REG_DEST = 1'b1;

    typedef struct packed {
        logic [ACTION_W-1:0]       action;
        logic [INDEX_W-1:0]        index;
        logic signed [VALUE_W-1:0] value;
    } t_in_word;

    typedef struct packed {
        logic [DEST_W-1:0]         dest_ch;
        logic signed [VALUE_W-1:0] mixed;
        logic                      clipped;
        logic                      last;
    } t_out_word;

    typedef struct packed {
        logic coef_wr;
        logic load_sample;
        logic prime;
        logic mac_issue;
        logic coef_ok;
        logic out_load;
        logic out_last;
    } t_dp_cmd;

    typedef struct packed {
        logic pipe_busy;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== rtl/cmm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module cmm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                      i_wr_data,
    input  wire logic                                  i_rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]                      o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/cmm_dp.sv =====
// Datapath: coefficient RAM, shared multiply-accumulate, accumulators, output register.
`default_nettype none

`include "channel_matrix_mixer_core_assert.svh"

module cmm_dp import cmm_pkg::*; #(
    parameter int MAX_CHANNELS   = CMM_MAX_CHANNELS,
    parameter int COEF_FRAC_BITS = CMM_COEF_FRAC_BITS
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_in_word i_in_word,
    input  wire t_dp_cmd  i_cmd,
    input  wire logic [((MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1)-1:0] i_d_idx,
    input  wire logic [((MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS * MAX_CHANNELS) : 1)-1:0]
                          i_rd_addr,
    input  wire logic     i_stall,
    output t_dp_sts       o_sts,
    output logic          o_valid,
    output t_out_word     o_out_word
);

    localparam int DEPTH = MAX_CHANNELS * MAX_CHANNELS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam logic signed [ACC_W:0] RND_HALF = (ACC_W + 1)'(1) << (COEF_FRAC_BITS - 1);

    logic signed [VALUE_W-1:0] ram_q;
    logic signed [VALUE_W-1:0] coef;
    logic signed [PROD_W-1:0]  mult;
    logic signed [PROD_W-1:0]  prime_ext;
    logic signed [PROD_W-1:0]  prime_add;

    logic signed [VALUE_W-1:0] r_sample;
    logic                      r_s1_vld;
    logic                      r_s1_ok;
    logic [DW-1:0]             r_s1_d;
    logic                      r_s2_vld;
    logic [DW-1:0]             r_s2_d;
    logic signed [PROD_W-1:0]  r_s2_prod;
    logic                      n_s2_vld;
    logic [DW-1:0]             n_s2_d;
    logic signed [PROD_W-1:0]  n_s2_prod;

    logic signed [ACC_W-1:0]   r_acc [MAX_CHANNELS];
    logic signed [ACC_W-1:0]   acc_cur;
    logic signed [ACC_W:0]     acc_sum;
    logic signed [ACC_W-1:0]   acc_new;

    logic signed [ACC_W-1:0]   acc_o;
    logic signed [ACC_W:0]     rnd;
    logic signed [ACC_W:0]     shr;
    logic                      fits;

    logic                      r_out_vld;
    logic                      n_out_vld;
    t_out_word                 r_out;
    t_out_word                 n_out;

    cmm_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_coef_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.coef_wr),
        .i_wr_addr (AW'(i_in_word.index)),
        .i_wr_data (i_in_word.value),
        .i_rd_en   (i_cmd.mac_issue),
        .i_rd_addr (i_rd_addr),
        .o_rd_data (ram_q)
    );

    // Multiply stage; a slot beyond the table reads as zero
    assign coef      = r_s1_ok ? ram_q : '0;
    assign mult      = r_sample * coef;
    assign prime_ext = {{(PROD_W - VALUE_W){i_in_word.value[VALUE_W-1]}}, i_in_word.value};
    assign prime_add = prime_ext <<< COEF_FRAC_BITS;

    always_comb begin
        n_s2_vld  = r_s1_vld | i_cmd.prime;
        n_s2_d    = r_s1_vld ? r_s1_d : i_d_idx;
        n_s2_prod = r_s1_vld ? mult : prime_add;
    end

    // Saturating accumulate
    always_comb begin
        acc_cur = r_acc[r_s2_d];
        acc_sum = {acc_cur[ACC_W-1], acc_cur}
                + {{(ACC_W + 1 - PROD_W){r_s2_prod[PROD_W-1]}}, r_s2_prod};
        if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
            acc_new = acc_sum[ACC_W] ? {1'b1, {(ACC_W - 1){1'b0}}}
                                     : {1'b0, {(ACC_W - 1){1'b1}}};
        end else begin
            acc_new = acc_sum[ACC_W-1:0];
        end
    end

    // Round half up, then saturate to a sample
    always_comb begin
        acc_o = r_acc[i_d_idx];
        rnd   = {acc_o[ACC_W-1], acc_o} + RND_HALF;
        shr   = rnd >>> COEF_FRAC_BITS;
        fits  = (&shr[ACC_W:VALUE_W-1]) | ~(|shr[ACC_W:VALUE_W-1]);
        n_out.dest_ch = DEST_W'(i_d_idx);
        n_out.clipped = ~fits;
        n_out.last    = i_cmd.out_last;
        if (fits) begin
            n_out.mixed = shr[VALUE_W-1:0];
        end else begin
            n_out.mixed = shr[ACC_W] ? {1'b1, {(VALUE_W - 1){1'b0}}}
                                     : {1'b0, {(VALUE_W - 1){1'b1}}};
        end
        if (i_cmd.out_load) begin
            n_out_vld = 1'b1;
        end else if (!i_stall) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_sample) begin
            r_sample <= i_in_word.value;
        end
        r_s1_ok   <= i_cmd.coef_ok;
        r_s1_d    <= i_d_idx;
        r_s2_d    <= n_s2_d;
        r_s2_prod <= n_s2_prod;
        if (i_cmd.out_load) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_s1_vld  <= i_cmd.mac_issue;
            r_s2_vld  <= n_s2_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                r_acc[i] <= '0;
            end
        end else if (i_cmd.out_load && i_cmd.out_last) begin
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                r_acc[i] <= '0;
            end
        end else if (r_s2_vld) begin
            r_acc[r_s2_d] <= acc_new;
        end
    end

    assign o_sts.pipe_busy = r_s1_vld | r_s2_vld;
    assign o_sts.out_free  = ~r_out_vld | ~i_stall;
    assign o_valid         = r_out_vld;
    assign o_out_word      = r_out;

    `CMM_ASSERT_NOW(a_prime_no_collide, i_clk, i_rst_n, i_cmd.prime, !r_s1_vld)
    `CMM_ASSERT_NOW(a_out_after_drain, i_clk, i_rst_n, i_cmd.out_load, !(r_s1_vld || r_s2_vld))

endmodule

`default_nettype wire

// ===== rtl/cmm_ctrl.sv =====
// Controller: decodes input words and sequences the destination sweeps.
`default_nettype none

`include "channel_matrix_mixer_core_assert.svh"

module cmm_ctrl import cmm_pkg::*; #(
    parameter int MAX_CHANNELS = CMM_MAX_CHANNELS
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    input  wire t_in_word i_in_word,
    input  wire logic [$clog2(MAX_CHANNELS + 1)-1:0] i_src_cnt,
    input  wire logic [$clog2(MAX_CHANNELS + 1)-1:0] i_dest_cnt,
    input  wire t_dp_sts  i_sts,
    output logic          o_stall,
    output t_dp_cmd       o_cmd,
    output logic [((MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1)-1:0] o_d_idx,
    output logic [((MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS * MAX_CHANNELS) : 1)-1:0]
                          o_rd_addr
);

    localparam int DEPTH = MAX_CHANNELS * MAX_CHANNELS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CW    = $clog2(MAX_CHANNELS + 1);
    localparam int SW    = $clog2(DEPTH + 64) + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MAC,
        S_DRAIN,
        S_OUT
    } t_state;

    t_state        r_state;
    logic [DW-1:0] r_d;
    logic [SW-1:0] r_slot;
    logic          r_frame_end;

    logic          accept;
    logic [SW-1:0] idx_w;
    logic [SW-1:0] ns_w;
    logic [SW-1:0] nd_w;
    logic          d_last;

    assign accept = i_valid & (r_state == S_IDLE);
    assign idx_w  = SW'(i_in_word.index);
    assign ns_w   = SW'(i_src_cnt);
    assign nd_w   = SW'(i_dest_cnt);
    assign d_last = (CW'(r_d) == (i_dest_cnt - CW'(1)));

    always_comb begin
        o_cmd.coef_wr     = 1'b0;
        o_cmd.load_sample = 1'b0;
        o_cmd.prime       = 1'b0;
        case (i_in_word.action)
            ACT_LOAD: begin
                o_cmd.coef_wr = accept & (idx_w < SW'(DEPTH));
            end
            ACT_SAMPLE: begin
                o_cmd.load_sample = accept & (idx_w < ns_w);
            end
            ACT_PRIME: begin
                o_cmd.prime = accept & (idx_w < nd_w);
            end
            default: begin
            end
        endcase
        o_cmd.mac_issue = (r_state == S_MAC);
        o_cmd.coef_ok   = (r_slot < SW'(DEPTH));
        o_cmd.out_load  = (r_state == S_OUT) & i_sts.out_free;
        o_cmd.out_last  = d_last;
    end

    assign o_d_idx   = o_cmd.prime ? DW'(i_in_word.index) : r_d;
    assign o_rd_addr = r_slot[AW-1:0];
    assign o_stall   = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_d         <= '0;
            r_slot      <= '0;
            r_frame_end <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (o_cmd.load_sample) begin
                        r_d         <= '0;
                        r_slot      <= idx_w;
                        r_frame_end <= (idx_w == ns_w - SW'(1));
                        r_state     <= S_MAC;
                    end
                end
                S_MAC: begin
                    if (d_last) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_d    <= r_d + DW'(1);
                        r_slot <= r_slot + ns_w;
                    end
                end
                S_DRAIN: begin
                    if (!i_sts.pipe_busy) begin
                        r_d     <= '0;
                        r_state <= r_frame_end ? S_OUT : S_IDLE;
                    end
                end
                S_OUT: begin
                    if (o_cmd.out_load) begin
                        if (d_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_d <= r_d + DW'(1);
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `CMM_ASSERT_NOW(a_mac_in_range, i_clk, i_rst_n, r_state == S_MAC, CW'(r_d) < i_dest_cnt)
    `CMM_ASSERT_NOW(a_out_pipe_idle, i_clk, i_rst_n, r_state == S_OUT, !i_sts.pipe_busy)
    `CMM_ASSERT_NEXT(a_last_ends_sweep, i_clk, i_rst_n, o_cmd.out_load && d_last, r_state == S_IDLE)

endmodule

`default_nettype wire

// ===== rtl/channel_matrix_mixer_core.sv =====
// Top level: channel matrix mixer with configuration registers, controller and datapath.
// Sequencing: a coefficient load or a prime does not stall the input; a source sample holds the input
//   stalled after acceptance while it sweeps the destinations, one destination per cycle
//   through the shared multiply-accumulate, and while its pipeline drains.
// No new word is taken until the sample has drained; the frame's last sample adds one
//   result word per cycle, dest_channels words, paced by the output stall.
// Reset (synchronous, active low): accumulators clear, channel counts return to 2; the
//   coefficient RAM is not cleared and holds garbage until written.
`default_nettype none

module channel_matrix_mixer_core import cmm_pkg::*; #(
    parameter int MAX_CHANNELS   = CMM_MAX_CHANNELS,
    parameter int COEF_FRAC_BITS = CMM_COEF_FRAC_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // input channel
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire t_in_word              i_in_word,
    // output channel
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output t_out_word                  o_out_word,
    // configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam int DEPTH = MAX_CHANNELS * MAX_CHANNELS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CW    = $clog2(MAX_CHANNELS + 1);

    logic [CFG_W-1:0] r_src_cfg;
    logic [CFG_W-1:0] r_dest_cfg;
    logic [CW-1:0]    src_cnt;
    logic [CW-1:0]    dest_cnt;
    logic             cfg_wr;

    t_dp_cmd          cmd;
    t_dp_sts          sts;
    logic [DW-1:0]    d_idx;
    logic [AW-1:0]    rd_addr;

    // Register file: zero-wait writes, register picked by paddr[2]
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_cfg  <= CFG_W'(2);
            r_dest_cfg <= CFG_W'(2);
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_SRC: begin
                    r_src_cfg <= pwdata[CFG_W-1:0];
                end
                REG_DEST: begin
                    r_dest_cfg <= pwdata[CFG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_SRC:  prdata = APB_DATA_W'(r_src_cfg);
            REG_DEST: prdata = APB_DATA_W'(r_dest_cfg);
            default:  prdata = '0;
        endcase
    end

    // Clamp the programmed counts to 1..MAX_CHANNELS
    always_comb begin
        if (r_src_cfg == '0) begin
            src_cnt = CW'(1);
        end else if (int'(r_src_cfg) > MAX_CHANNELS) begin
            src_cnt = CW'(MAX_CHANNELS);
        end else begin
            src_cnt = CW'(r_src_cfg);
        end
        if (r_dest_cfg == '0) begin
            dest_cnt = CW'(1);
        end else if (int'(r_dest_cfg) > MAX_CHANNELS) begin
            dest_cnt = CW'(MAX_CHANNELS);
        end else begin
            dest_cnt = CW'(r_dest_cfg);
        end
    end

    // Sequencer: decode each word, sweep the destinations, then emit the frame
    cmm_ctrl #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_in_word  (i_in_word),
        .i_src_cnt  (src_cnt),
        .i_dest_cnt (dest_cnt),
        .i_sts      (sts),
        .o_stall    (o_stall),
        .o_cmd      (cmd),
        .o_d_idx    (d_idx),
        .o_rd_addr  (rd_addr)
    );

    // Coefficient RAM, shared MAC, accumulators and the output register
    cmm_dp #(
        .MAX_CHANNELS   (MAX_CHANNELS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_word  (i_in_word),
        .i_cmd      (cmd),
        .i_d_idx    (d_idx),
        .i_rd_addr  (rd_addr),
        .i_stall    (i_stall),
        .o_sts      (sts),
        .o_valid    (o_valid),
        .o_out_word (o_out_word)
    );

endmodule

`default_nettype wire

// ===== verif/cmm_mix_checker.sv =====
// Checker for the channel matrix mixer: tracks channels and config, predicts and compares words.
module cmm_mix_checker import cmm_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    input  wire logic                  i_in_stall,
    input  t_in_word                   i_in_word,
    input  wire logic                  i_out_valid,
    input  wire logic                  i_out_stall,
    input  t_out_word                  i_out_word,
    input  wire logic                  i_psel,
    input  wire logic                  i_penable,
    input  wire logic                  i_pwrite,
    input  wire logic                  i_pready,
    input  wire logic [APB_ADDR_W-1:0] i_paddr,
    input  wire logic [APB_DATA_W-1:0] i_pwdata,
    output int                         o_fail_count,
    output int                         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     TABLE_DEPTH = CMM_MAX_CHANNELS * CMM_MAX_CHANNELS;
    localparam int     RESET_COUNT = 2;
    localparam longint ACC_HI      = (longint'(1) <<< (ACC_W - 1)) - 1;
    localparam longint ACC_LO      = -ACC_HI - 1;
    localparam longint ROUND_HALF  = longint'(1) <<< (CMM_COEF_FRAC_BITS - 1);
    localparam longint MIXED_HI    = 32767;
    localparam longint MIXED_LO    = -32768;

    logic signed [VALUE_W-1:0] coef_mem [TABLE_DEPTH];
    longint                    mix_acc  [CMM_MAX_CHANNELS];
    logic [CFG_W-1:0]          src_cfg;
    logic [CFG_W-1:0]          dest_cfg;
    t_out_word                 mixed_due [$];
    int                        fails = 0;

    function automatic int unsigned active_count(input logic [CFG_W-1:0] n);
        if (n == 0) return 1;
        if (n > CMM_MAX_CHANNELS) return CMM_MAX_CHANNELS;
        return n;
    endfunction

    function automatic longint acc_sat_add(input longint a, input longint b);
        longint s;
        s = a + b;
        if (s > ACC_HI) return ACC_HI;
        if (s < ACC_LO) return ACC_LO;
        return s;
    endfunction

    // Advance the mix state by one accepted word; queue the frame's words on its last sample.
    task automatic advance_mix(input t_in_word w);
        int unsigned ns;
        int unsigned nd;
        longint      v;
        longint      r;
        t_out_word   res;
        ns = active_count(src_cfg);
        nd = active_count(dest_cfg);
        v  = longint'($signed(w.value));
        case (w.action)
            ACT_LOAD: begin
                coef_mem[w.index] = w.value;
            end
            ACT_PRIME: begin
                if (w.index < nd)
                    mix_acc[w.index] = acc_sat_add(mix_acc[w.index], v <<< CMM_COEF_FRAC_BITS);
            end
            ACT_SAMPLE: begin
                if (w.index < ns) begin
                    for (int unsigned d = 0; d < nd; d++)
                        mix_acc[d] = acc_sat_add(mix_acc[d],
                                                 v * longint'(coef_mem[d * ns + w.index]));
                    if (w.index == ns - 1) begin
                        for (int unsigned d = 0; d < nd; d++) begin
                            r = (mix_acc[d] + ROUND_HALF) >>> CMM_COEF_FRAC_BITS;
                            res.clipped = 1'b0;
                            if (r > MIXED_HI) begin
                                r = MIXED_HI;
                                res.clipped = 1'b1;
                            end else if (r < MIXED_LO) begin
                                r = MIXED_LO;
                                res.clipped = 1'b1;
                            end
                            res.dest_ch = DEST_W'(d);
                            res.mixed   = VALUE_W'(r);
                            res.last    = (d == nd - 1);
                            mixed_due.insert(mixed_due.size(), res);
                        end
                        foreach (mix_acc[d]) mix_acc[d] = 0;
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_mixed(input t_out_word got);
        t_out_word want;
        if (mixed_due.size() == 0) begin
            $error("unexpected mixed word: dest_ch %0d mixed %0d",
                   got.dest_ch, got.mixed);
            fails++;
            return;
        end
        want = mixed_due.pop_front();
        if (got !== want) begin
            fails++;
            if (got.dest_ch !== want.dest_ch)
                $error("dest_ch: expected %0d, got %0d", want.dest_ch, got.dest_ch);
            if (got.mixed !== want.mixed)
                $error("mixed: expected %0d, got %0d", want.mixed, got.mixed);
            if (got.clipped !== want.clipped)
                $error("clipped: expected %0d, got %0d", want.clipped, got.clipped);
            if (got.last !== want.last)
                $error("last: expected %0d, got %0d", want.last, got.last);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (mix_acc[d]) mix_acc[d] = 0;
            src_cfg  = CFG_W'(RESET_COUNT);
            dest_cfg = CFG_W'(RESET_COUNT);
            mixed_due.delete();
        end else begin
            // Drain before predicting: a word accepted now cannot be answered at this edge.
            if (i_out_valid && !i_out_stall) check_mixed(i_out_word);
            if (i_in_valid && !i_in_stall) advance_mix(i_in_word);
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == REG_DEST) dest_cfg = i_pwdata[CFG_W-1:0];
                else src_cfg = i_pwdata[CFG_W-1:0];
            end
        end
        o_fail_count <= fails;
        o_pending    <= mixed_due.size();
    end

endmodule

// ===== verif/tb_top.sv =====
// Testbench top for the channel matrix mixer: clock, reset, stimulus, stall patterns, verdict.
module tb_top import cmm_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH     = CMM_MAX_CHANNELS * CMM_MAX_CHANNELS;
    localparam int RESET_CYCLES    = 7;
    localparam int MAX_WAIT        = 17;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTLE_CYCLES   = 24;   // covers a destination sweep plus pipeline drain
    localparam int DRAIN_CYCLES    = 40;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int PHASES          = 8;
    localparam int PHASE_ITEMS     = 13;

    // Spare action code: the block must ignore it
    localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;

    localparam logic [APB_ADDR_W-1:0] ADDR_SRC  = {REG_SRC, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_DEST = {REG_DEST, 2'b00};

    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  i_valid   = 1'b0;
    logic                  o_stall;
    t_in_word              i_in_word = '0;
    logic                  o_valid;
    logic                  i_stall   = 1'b0;
    t_out_word             o_out_word;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [APB_ADDR_W-1:0] paddr     = '0;
    logic [APB_DATA_W-1:0] pwdata    = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int                    fail_count;
    int                    pending;
    int                    idle_cycles   = 0;
    bit                    send_dense    = 1'b0;
    bit                    recv_dense    = 1'b0;
    bit                    hold_off_req  = 1'b0;
    logic [CFG_W-1:0]      src_now       = CFG_W'(2);
    logic [CFG_W-1:0]      dest_now      = CFG_W'(2);

    channel_matrix_mixer_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_in_word  (i_in_word),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_word (o_out_word),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    cmm_mix_checker mix_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_in_word    (i_in_word),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_out_word   (o_out_word),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Watchdog: end the run when no word and no register write moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) ||
            (psel && penable && pready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("channel_matrix_mixer_core verification failed");
            $finish;
        end
    end

    function automatic int unsigned active_count(input logic [CFG_W-1:0] n);
        if (n == 0) return 1;
        if (n > CMM_MAX_CHANNELS) return CMM_MAX_CHANNELS;
        return n;
    endfunction

    // Sample values: mostly moderate so that not every frame clips, with full range and
    // the rails mixed in.
    function automatic logic signed [VALUE_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0, 1:    return VALUE_W'($urandom);
            2:       return 16'sh7FFF;
            3:       return 16'sh8000;
            default: return VALUE_W'(int'($urandom_range(0, 4095)) - 2048);
        endcase
    endfunction

    // Coefficients: mostly within +-1.0 in Q4.12, some zero, some anywhere.
    function automatic logic signed [VALUE_W-1:0] pick_coef();
        case ($urandom_range(0, 5))
            0:       return VALUE_W'($urandom);
            1:       return '0;
            default: return VALUE_W'(int'($urandom_range(0, 8192)) - 4096);
        endcase
    endfunction

    // Offer one word after a random gap; return at the edge that accepts it.
    task automatic send_word(input logic [ACTION_W-1:0] action,
                             input logic [INDEX_W-1:0] index,
                             input logic signed [VALUE_W-1:0] value);
        int unsigned gap;
        t_in_word    w;
        if ($urandom_range(0, 19) == 0) send_dense = !send_dense;
        gap      = send_dense ? 0 : $urandom_range(0, MAX_WAIT);
        w.action = action;
        w.index  = index;
        w.value  = value;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_word <= w;
        do @(posedge i_clk); while (o_stall !== 1'b0);
    endtask

    // Two-phase APB write; psel then drops before any following write, so
    // back-to-back writes never lower and raise psel in the same step.
    task automatic write_reg(input logic [APB_ADDR_W-1:0] addr, input logic [CFG_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= APB_DATA_W'(data);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Drop valid, wait until every mixed word has come back and the block is
    // quiet, then change both channel counts. The pending count is registered
    // behind the accepting edge, so step the clock before reading it.
    task automatic set_counts(input logic [CFG_W-1:0] src, input logic [CFG_W-1:0] dest);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_reg(ADDR_SRC, src);
        write_reg(ADDR_DEST, dest);
        src_now  = src;
        dest_now = dest;
    endtask

    // Random traffic: mostly complete frames (optional coefficient reloads and
    // primes, then every source channel in order), the rest noise: spare action,
    // out-of-range indexes, stray samples that may end a frame early, loads.
    // Words the block simply drops do not count toward the quota.
    task automatic run_phase(input int unsigned quota);
        int unsigned sent;
        int unsigned ns;
        int unsigned nd;
        sent = 0;
        ns   = active_count(src_now);
        nd   = active_count(dest_now);
        while (sent < quota) begin
            if ($urandom_range(0, 99) < 70) begin
                if ($urandom_range(0, 3) == 0) begin
                    repeat ($urandom_range(1, 3)) begin
                        send_word(ACT_LOAD, INDEX_W'($urandom_range(0, TABLE_DEPTH - 1)),
                                  pick_coef());
                        sent++;
                    end
                end
                for (int unsigned k = 0; k < nd; k++) begin
                    if ($urandom_range(0, 2) == 0) begin
                        send_word(ACT_PRIME, INDEX_W'(k), pick_sample());
                        sent++;
                    end
                end
                for (int unsigned k = 0; k < ns; k++) begin
                    send_word(ACT_SAMPLE, INDEX_W'(k), pick_sample());
                    sent++;
                end
            end else begin
                case ($urandom_range(0, 4))
                    0: send_word(ACT_SPARE, INDEX_W'($urandom), VALUE_W'($urandom));
                    1: send_word(ACT_SAMPLE, INDEX_W'($urandom_range(ns, 63)), pick_sample());
                    2: send_word(ACT_PRIME, INDEX_W'($urandom_range(nd, 63)), pick_sample());
                    3: begin
                        send_word(ACT_SAMPLE, INDEX_W'($urandom_range(0, ns - 1)), pick_sample());
                        sent++;
                    end
                    default: begin
                        send_word(ACT_LOAD, INDEX_W'($urandom_range(0, TABLE_DEPTH - 1)),
                                  pick_coef());
                        sent++;
                    end
                endcase
            end
        end
    endtask

    // Output side: random stall per word, with dense stretches; one long
    // hold-off on request so the block backs up and stalls its input.
    initial begin : drain_side
        int unsigned hold;
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold = HOLD_OFF_CYCLES;
            end else begin
                if ($urandom_range(0, 19) == 0) recv_dense = !recv_dense;
                hold = recv_dense ? 0 : $urandom_range(0, MAX_WAIT);
            end
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (o_valid !== 1'b1);
        end
    end

    initial begin : stimulus
        logic [CFG_W-1:0] src_set  [PHASES];
        logic [CFG_W-1:0] dest_set [PHASES];
        // Both extremes of each count, out-of-range values on either side, then odd mixes.
        src_set  = '{4'd8, 4'd1, 4'd0,  4'd15, 4'd3, 4'd8, 4'd1, 4'd0};
        dest_set = '{4'd8, 4'd1, 4'd15, 4'd0,  4'd5, 4'd1, 4'd8, 4'd0};
        src_set[PHASES-1]  = CFG_W'($urandom_range(0, 15));
        dest_set[PHASES-1] = CFG_W'($urandom_range(0, 15));

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The RAM powers up with garbage: fill every slot before any sample reads it.
        for (int k = 0; k < TABLE_DEPTH; k++)
            send_word(ACT_LOAD, INDEX_W'(k), pick_coef());

        // Directed part at the reset counts (2 sources, 2 destinations).
        // Table slot = dest * 2 + src.
        send_word(ACT_LOAD, 6'd0, 16'sh7FFF);
        send_word(ACT_LOAD, 6'd1, 16'sh8000);
        send_word(ACT_LOAD, 6'd2, 16'sh1000);          // unity gain
        send_word(ACT_LOAD, 6'd3, 16'sh0000);
        send_word(ACT_PRIME, 6'd0, 16'sh7FFF);
        send_word(ACT_PRIME, 6'd2, 16'sh7FFF);         // beyond dest count: dropped
        send_word(ACT_SPARE, 6'd63, 16'shFFFF);        // spare action: dropped
        send_word(ACT_SAMPLE, 6'd5, 16'sh7FFF);        // beyond source count: dropped
        send_word(ACT_SAMPLE, 6'd63, 16'sh8000);
        send_word(ACT_SAMPLE, 6'd0, 16'sh7FFF);
        send_word(ACT_SAMPLE, 6'd1, 16'sh8000);        // ends frame, dest 0 clips high, dest 1 at rail
        send_word(ACT_PRIME, 6'd1, 16'sh8000);
        send_word(ACT_PRIME, 6'd1, 16'sh8000);         // repeated prime adds again
        send_word(ACT_SAMPLE, 6'd0, 16'sh8000);
        send_word(ACT_SAMPLE, 6'd0, 16'sh8000);        // repeated source sample
        send_word(ACT_SAMPLE, 6'd1, 16'sh0000);        // ends frame, both clip low
        // Round half up: +0.5 LSB goes to 1, -0.5 LSB goes to 0
        send_word(ACT_LOAD, 6'd0, 16'sh0800);
        send_word(ACT_LOAD, 6'd1, 16'sh0000);
        send_word(ACT_LOAD, 6'd2, -16'sh0800);
        send_word(ACT_SAMPLE, 6'd0, 16'sh0001);
        send_word(ACT_SAMPLE, 6'd1, 16'sh0000);
        send_word(ACT_LOAD, 6'd63, pick_coef());

        for (int ph = 0; ph < PHASES; ph++) begin
            set_counts(src_set[ph], dest_set[ph]);
            // Full 8x8 frames: hold the output off for a long stretch while words keep coming.
            if (ph == 0) hold_off_req = 1'b1;
            run_phase((ph == 0) ? 2 * PHASE_ITEMS : PHASE_ITEMS);
        end
        i_valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (pending != 0)
            $error("%0d mixed words never arrived", pending);
        if (fail_count == 0 && pending == 0) begin
            $display("channel_matrix_mixer_core verification clean");
        end else begin
            $display("channel_matrix_mixer_core verification failed");
        end
        $finish;
    end

endmodule
